>>> rtl/core/mlfq_pkg.sv
// ============================================================================
// mlfq_pkg
// Shared types, codes and reset values of the multilevel feedback queue
// scheduler.
// ============================================================================
package mlfq_pkg;

   localparam int MAX_LEVELS_DEF = 4;
   localparam int MAX_TASKS_DEF  = 64;

   localparam int TIME_W  = 32;
   localparam int ID_W    = 16;
   localparam int BURST_W = 16;
   localparam int QUANT_W = 16;
   localparam int LVCFG_W = 3;
   localparam int CSR_W   = 32;
   localparam int CSRI_W  = 3;
   localparam int STAT_W  = 2;

   localparam logic [CSRI_W-1:0] CSR_LEVELS = 3'd0;
   localparam logic [CSRI_W-1:0] CSR_PERIOD = 3'd1;
   localparam logic [CSRI_W-1:0] CSR_QUANT0 = 3'd2;
   localparam logic [CSRI_W-1:0] CSR_QUANT1 = 3'd3;
   localparam logic [CSRI_W-1:0] CSR_QUANT2 = 3'd4;
   localparam logic [CSRI_W-1:0] CSR_QUANT3 = 3'd5;

   localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_RAN      = 2'd1;
   localparam logic [STAT_W-1:0] ST_IDLE     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

   localparam logic ACT_ARRIVE   = 1'b0;
   localparam logic ACT_DISPATCH = 1'b1;

   localparam logic [LVCFG_W-1:0] LEVELS_RST = 3'd3;
   localparam logic [TIME_W-1:0]  PERIOD_RST = 32'd100;
   localparam logic [QUANT_W-1:0] QUANT0_RST = 16'd8;
   localparam logic [QUANT_W-1:0] QUANT1_RST = 16'd16;
   localparam logic [QUANT_W-1:0] QUANT2_RST = 16'd32;
   localparam logic [QUANT_W-1:0] QUANT3_RST = 16'd64;

   typedef struct packed {
      logic              started;
      logic [ID_W-1:0]   task_id;
      logic [BURST_W-1:0] remaining;
   } slot_entry_type;

   typedef struct packed {
      logic set;
      logic clr;
   } alloc_cmd_type;

endpackage

>>> rtl/core/mlfq_ram.sv
// ============================================================================
// mlfq_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mlfq_slot_alloc.sv
// ============================================================================
// mlfq_slot_alloc
// Busy map of task slots with a lowest-free-slot search.
// ============================================================================
module mlfq_slot_alloc #(
   parameter int MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mlfq_pkg::alloc_cmd_type      cmd,
   input  logic [$clog2(MAX_TASKS)-1:0] set_idx,
   input  logic [$clog2(MAX_TASKS)-1:0] clr_idx,
   output logic [$clog2(MAX_TASKS)-1:0] free_idx,
   output logic                         full
);

   localparam int SW = $clog2(MAX_TASKS);

   logic [MAX_TASKS-1:0] busy_ff;
   logic [MAX_TASKS-1:0] busy_in;

   always_comb begin
      busy_in = busy_ff;
      if (cmd.set) begin
         busy_in[set_idx] = 1'b1;
      end
      if (cmd.clr) begin
         busy_in[clr_idx] = 1'b0;
      end
   end

   always_comb begin
      free_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = SW'(i);
         end
      end
   end

   assign full = &busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   a_free_is_free: assert property (@(posedge clock) disable iff (reset)
      !full |-> !busy_ff[free_idx]) else $error("free slot is marked busy");
   a_set_sticks: assert property (@(posedge clock) disable iff (reset)
      cmd.set && !(cmd.clr && clr_idx == set_idx) |=> busy_ff[$past(set_idx)])
      else $error("allocated slot not marked busy");
   a_clr_sticks: assert property (@(posedge clock) disable iff (reset)
      cmd.clr && !cmd.set |=> !busy_ff[$past(clr_idx)])
      else $error("released slot still busy");

endmodule

>>> rtl/core/multilevel_feedback_queue_scheduler_unit.sv
// ============================================================================
// multilevel_feedback_queue_scheduler_unit
// Multilevel feedback queue scheduler with queues and task slots held in RAM.
//
// A transaction enters when start is high and busy is low. An arrive
// transaction queues a new task on level zero, or reports full if no slot is
// free; its result strobes on rsp_valid in the next cycle and busy stays low.
// A dispatch transaction raises busy, picks the level and reads the queue RAM,
// reads the slot RAM, updates the task and then shows its result from the
// result register. Busy is low again while the result is shown, so a new
// transaction can enter in that cycle. A priority boost before the slice moves
// each task queued above level zero to level zero, reading and then writing
// the queue RAM for each task moved. A dispatch with nothing queued answers
// in the next cycle without raising busy. Each result is shown for exactly
// one cycle; the receiver cannot stall it. Configuration writes on the csr_
// port take effect at once; the user must make them only while busy is low;
// the block does not enforce it. Reset clears the queue pointers, the slot
// busy map and simulated time and restores the register defaults; the RAMs
// need no clearing pass, so the block accepts transactions right after reset.
// ============================================================================
module multilevel_feedback_queue_scheduler_unit #(
   parameter int MAX_LEVELS = mlfq_pkg::MAX_LEVELS_DEF,
   parameter int MAX_TASKS  = mlfq_pkg::MAX_TASKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [mlfq_pkg::ID_W-1:0]       req_task_id,
   input  logic [mlfq_pkg::BURST_W-1:0]    req_burst_time,
   input  logic [mlfq_pkg::TIME_W-1:0]     req_arrival_time,
   output logic                            rsp_valid,
   output logic [mlfq_pkg::STAT_W-1:0]     rsp_status,
   output logic [mlfq_pkg::ID_W-1:0]       rsp_ran_id,
   output logic [mlfq_pkg::BURST_W-1:0]    rsp_run_length,
   output logic                            rsp_first_run,
   output logic [mlfq_pkg::TIME_W-1:0]     rsp_slice_start,
   output logic                            rsp_finished,
   output logic [mlfq_pkg::TIME_W-1:0]     rsp_time_now,
   output logic                            rsp_boosted,
   input  logic                            csr_we,
   input  logic [mlfq_pkg::CSRI_W-1:0]     csr_index,
   input  logic [mlfq_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int SW  = $clog2(MAX_TASKS);
   localparam int CW  = $clog2(MAX_TASKS + 1);
   localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int AW  = LW + SW;
   localparam int FIFO_DEPTH = 2 ** AW;
   localparam int SLOT_W = $bits(mlfq_pkg::slot_entry_type);
   localparam int TW  = mlfq_pkg::TIME_W;
   localparam int QW  = mlfq_pkg::QUANT_W;
   localparam int VW  = mlfq_pkg::LVCFG_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BOOST_RD,
      S_BOOST_WR,
      S_POP,
      S_SLOT,
      S_EXEC
   } state_type;

   function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
      ptr_inc = (p == SW'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
   endfunction

   state_type state_ff, state_in;

   logic [VW-1:0] levels_ff, levels_in;
   logic [TW-1:0] period_ff, period_in;
   logic [QW-1:0] quant0_ff, quant0_in;
   logic [QW-1:0] quant1_ff, quant1_in;
   logic [QW-1:0] quant2_ff, quant2_in;
   logic [QW-1:0] quant3_ff, quant3_in;

   logic [SW-1:0] head_ff  [MAX_LEVELS];
   logic [SW-1:0] head_in  [MAX_LEVELS];
   logic [SW-1:0] tail_ff  [MAX_LEVELS];
   logic [SW-1:0] tail_in  [MAX_LEVELS];
   logic [CW-1:0] count_ff [MAX_LEVELS];
   logic [CW-1:0] count_in [MAX_LEVELS];

   logic [TW-1:0] time_ff, time_in;
   logic [TW-1:0] boost_at_ff, boost_at_in;
   logic          boosted_ff, boosted_in;
   logic [LW:0]   bst_lvl_ff, bst_lvl_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [SW-1:0] slot_ff, slot_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mlfq_pkg::STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [mlfq_pkg::ID_W-1:0]       rsp_ran_id_ff, rsp_ran_id_in;
   logic [mlfq_pkg::BURST_W-1:0]    rsp_run_ff, rsp_run_in;
   logic                            rsp_first_ff, rsp_first_in;
   logic [TW-1:0]                   rsp_start_ff, rsp_start_in;
   logic                            rsp_fin_ff, rsp_fin_in;
   logic [TW-1:0]                   rsp_now_ff, rsp_now_in;
   logic                            rsp_bst_ff, rsp_bst_in;

   logic          fifo_we;
   logic [AW-1:0] fifo_waddr;
   logic [SW-1:0] fifo_wdata;
   logic [AW-1:0] fifo_raddr;
   logic [SW-1:0] fifo_rdata;

   logic                     slot_we;
   logic [SW-1:0]            slot_waddr;
   mlfq_pkg::slot_entry_type slot_wdata;
   logic [SW-1:0]            slot_raddr;
   logic [SLOT_W-1:0]        slot_rdata_raw;
   mlfq_pkg::slot_entry_type slot_rdata;

   mlfq_pkg::alloc_cmd_type alloc_cmd;
   logic [SW-1:0]           free_idx;
   logic                    table_full;

   logic          any_queued;
   logic [CW:0]   total_count;
   logic [LW-1:0] pick_lvl;
   logic [LW-1:0] bst_idx;
   logic [LW-1:0] dest_lvl;
   logic [VW-1:0] lim;
   logic [VW-1:0] lvl_ext;
   logic [QW-1:0] quant_raw;
   logic [QW-1:0] quant;
   logic [mlfq_pkg::BURST_W-1:0] run_len;
   logic [mlfq_pkg::BURST_W-1:0] rem_new;

   assign slot_rdata = mlfq_pkg::slot_entry_type'(slot_rdata_raw);
   assign bst_idx    = bst_lvl_ff[LW-1:0];

   mlfq_ram #(
      .WIDTH (SW),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rdata)
   );

   mlfq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_TASKS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata_raw)
   );

   mlfq_slot_alloc #(
      .MAX_TASKS (MAX_TASKS)
   ) u_slot_alloc (
      .clock    (clock),
      .reset    (reset),
      .cmd      (alloc_cmd),
      .set_idx  (free_idx),
      .clr_idx  (slot_ff),
      .free_idx (free_idx),
      .full     (table_full)
   );

   always_comb begin
      any_queued  = 1'b0;
      total_count = '0;
      pick_lvl    = '0;
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            pick_lvl = LW'(i);
         end
      end
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            any_queued = 1'b1;
         end
         total_count = total_count + (CW + 1)'(count_ff[i]);
      end
   end

   always_comb begin
      if (levels_ff == '0) begin
         lim = VW'(1);
      end else if (levels_ff > VW'(MAX_LEVELS)) begin
         lim = VW'(MAX_LEVELS);
      end else begin
         lim = levels_ff;
      end
      lvl_ext  = VW'(lvl_ff);
      dest_lvl = ((lvl_ext + 1'b1) < lim) ? LW'(lvl_ext + 1'b1) : lvl_ff;
      case (lvl_ext)
         3'd0: quant_raw = quant0_ff;
         3'd1: quant_raw = quant1_ff;
         3'd2: quant_raw = quant2_ff;
         default: quant_raw = quant3_ff;
      endcase
      quant   = (quant_raw == '0) ? QW'(1) : quant_raw;
      run_len = (slot_rdata.remaining <= quant) ? slot_rdata.remaining : quant;
      rem_new = slot_rdata.remaining - run_len;
   end

   always_comb begin
      levels_in = levels_ff;
      period_in = period_ff;
      quant0_in = quant0_ff;
      quant1_in = quant1_ff;
      quant2_in = quant2_ff;
      quant3_in = quant3_ff;
      if (csr_we) begin
         case (csr_index)
            mlfq_pkg::CSR_LEVELS: levels_in = csr_wdata[VW-1:0];
            mlfq_pkg::CSR_PERIOD: period_in = csr_wdata[TW-1:0];
            mlfq_pkg::CSR_QUANT0: quant0_in = csr_wdata[QW-1:0];
            mlfq_pkg::CSR_QUANT1: quant1_in = csr_wdata[QW-1:0];
            mlfq_pkg::CSR_QUANT2: quant2_in = csr_wdata[QW-1:0];
            mlfq_pkg::CSR_QUANT3: quant3_in = csr_wdata[QW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      time_in     = time_ff;
      boost_at_in = boost_at_ff;
      boosted_in  = boosted_ff;
      bst_lvl_in  = bst_lvl_ff;
      lvl_in      = lvl_ff;
      slot_in     = slot_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_ran_id_in = rsp_ran_id_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_bst_in    = rsp_bst_ff;

      fifo_we    = 1'b0;
      fifo_waddr = '0;
      fifo_wdata = '0;
      fifo_raddr = '0;
      slot_we    = 1'b0;
      slot_waddr = '0;
      slot_wdata = '0;
      slot_raddr = '0;
      alloc_cmd  = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_ran_id_in = '0;
               rsp_run_in    = '0;
               rsp_first_in  = 1'b0;
               rsp_start_in  = '0;
               rsp_fin_in    = 1'b0;
               rsp_bst_in    = 1'b0;
               if (req_action == mlfq_pkg::ACT_ARRIVE) begin
                  if (!any_queued && req_arrival_time > time_ff) begin
                     time_in = req_arrival_time;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_now_in   = time_in;
                  if (table_full) begin
                     rsp_status_in = mlfq_pkg::ST_FULL;
                  end else begin
                     rsp_status_in = mlfq_pkg::ST_ACCEPTED;
                     alloc_cmd.set = 1'b1;
                     slot_we       = 1'b1;
                     slot_waddr    = free_idx;
                     slot_wdata.started   = 1'b0;
                     slot_wdata.task_id   = req_task_id;
                     slot_wdata.remaining = req_burst_time;
                     fifo_we       = 1'b1;
                     fifo_waddr    = {LW'(0), tail_ff[0]};
                     fifo_wdata    = free_idx;
                     tail_in[0]    = ptr_inc(tail_ff[0]);
                     count_in[0]   = count_ff[0] + 1'b1;
                  end
               end else if (!any_queued) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mlfq_pkg::ST_IDLE;
                  rsp_now_in    = time_ff;
               end else if (time_ff >= boost_at_ff) begin
                  boost_at_in = boost_at_ff + period_ff;
                  boosted_in  = 1'b1;
                  bst_lvl_in  = (LW + 1)'(1);
                  state_in    = S_BOOST_RD;
               end else begin
                  boosted_in = 1'b0;
                  state_in   = S_POP;
               end
            end
         end
         S_BOOST_RD: begin
            if (bst_lvl_ff >= (LW + 1)'(MAX_LEVELS)) begin
               state_in = S_POP;
            end else if (count_ff[bst_idx] == '0) begin
               bst_lvl_in = bst_lvl_ff + 1'b1;
            end else begin
               fifo_raddr        = {bst_idx, head_ff[bst_idx]};
               head_in[bst_idx]  = ptr_inc(head_ff[bst_idx]);
               count_in[bst_idx] = count_ff[bst_idx] - 1'b1;
               state_in          = S_BOOST_WR;
            end
         end
         S_BOOST_WR: begin
            fifo_we     = 1'b1;
            fifo_waddr  = {LW'(0), tail_ff[0]};
            fifo_wdata  = fifo_rdata;
            tail_in[0]  = ptr_inc(tail_ff[0]);
            count_in[0] = count_ff[0] + 1'b1;
            state_in    = S_BOOST_RD;
         end
         S_POP: begin
            lvl_in             = pick_lvl;
            fifo_raddr         = {pick_lvl, head_ff[pick_lvl]};
            head_in[pick_lvl]  = ptr_inc(head_ff[pick_lvl]);
            count_in[pick_lvl] = count_ff[pick_lvl] - 1'b1;
            state_in           = S_SLOT;
         end
         S_SLOT: begin
            slot_in    = fifo_rdata;
            slot_raddr = fifo_rdata;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            slot_we              = 1'b1;
            slot_waddr           = slot_ff;
            slot_wdata.started   = 1'b1;
            slot_wdata.task_id   = slot_rdata.task_id;
            slot_wdata.remaining = rem_new;
            time_in              = time_ff + TW'(run_len);
            if (rem_new == '0) begin
               alloc_cmd.clr = 1'b1;
            end else begin
               fifo_we            = 1'b1;
               fifo_waddr         = {dest_lvl, tail_ff[dest_lvl]};
               fifo_wdata         = slot_ff;
               tail_in[dest_lvl]  = ptr_inc(tail_ff[dest_lvl]);
               count_in[dest_lvl] = count_ff[dest_lvl] + 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = mlfq_pkg::ST_RAN;
            rsp_ran_id_in = slot_rdata.task_id;
            rsp_run_in    = run_len;
            rsp_first_in  = !slot_rdata.started;
            rsp_start_in  = time_ff;
            rsp_fin_in    = (rem_new == '0);
            rsp_now_in    = time_in;
            rsp_bst_in    = boosted_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         levels_ff    <= mlfq_pkg::LEVELS_RST;
         period_ff    <= mlfq_pkg::PERIOD_RST;
         quant0_ff    <= mlfq_pkg::QUANT0_RST;
         quant1_ff    <= mlfq_pkg::QUANT1_RST;
         quant2_ff    <= mlfq_pkg::QUANT2_RST;
         quant3_ff    <= mlfq_pkg::QUANT3_RST;
         time_ff      <= '0;
         boost_at_ff  <= mlfq_pkg::PERIOD_RST;
         boosted_ff   <= 1'b0;
         bst_lvl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         levels_ff    <= levels_in;
         period_ff    <= period_in;
         quant0_ff    <= quant0_in;
         quant1_ff    <= quant1_in;
         quant2_ff    <= quant2_in;
         quant3_ff    <= quant3_in;
         time_ff      <= time_in;
         boost_at_ff  <= boost_at_in;
         boosted_ff   <= boosted_in;
         bst_lvl_ff   <= bst_lvl_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
      lvl_ff        <= lvl_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ran_id_ff <= rsp_ran_id_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_bst_ff    <= rsp_bst_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_ran_id      = rsp_ran_id_ff;
   assign rsp_run_length  = rsp_run_ff;
   assign rsp_first_run   = rsp_first_ff;
   assign rsp_slice_start = rsp_start_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_time_now    = rsp_now_ff;
   assign rsp_boosted     = rsp_bst_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while a transaction is busy");
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> rsp_valid && rsp_status == mlfq_pkg::ST_RAN)
      else $error("slice finished without a result");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      total_count <= (CW + 1)'(MAX_TASKS)) else $error("more tasks queued than slots");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |-> any_queued) else $error("pop from empty queues");

endmodule
